### hdl/mcba_pkg.sv
// Package for the multichannel converter block averager.
// Holds field widths, reset values, register index codes and shared types.
// No dependencies; every other file of the block imports it.
package mcba_pkg;

	localparam int SAMPLE_W         = 10;
	localparam int BIAS_W           = 10;
	localparam int SHIFT_W          = 4;
	localparam int CNT_W            = 16;
	localparam int CH_W             = 2;
	localparam int ADJ_W            = 11;
	localparam int SPREAD_W         = 11;
	// 65535 samples of magnitude 1023 stay below 2**26, so 27 signed bits hold any sum.
	localparam int ACC_W            = 27;
	localparam int CFG_CH           = 3;
	localparam int IDX_W            = 3;
	localparam int DATA_W           = 16;
	localparam int NUM_CHANNELS_DEF = 3;
	localparam int QDEPTH           = 2;
	localparam int QPTR_W           = $clog2(QDEPTH);
	localparam int QCNT_W           = $clog2(QDEPTH + 1);

	localparam logic signed [ADJ_W-1:0] MIN_RESTART = 11'sd1000;
	localparam logic signed [ADJ_W-1:0] MAX_RESTART = -11'sd1000;
	localparam logic [ADJ_W-2:0]        MEAN_MAX    = 10'd1023;

	localparam logic [BIAS_W-1:0]  BIAS_RST_CH0 = 10'd511;
	localparam logic [BIAS_W-1:0]  BIAS_RST_CH1 = 10'd511;
	localparam logic [BIAS_W-1:0]  BIAS_RST_CH2 = 10'd0;
	localparam logic [SHIFT_W-1:0] SHIFT_RST    = 4'd0;
	localparam logic [CNT_W-1:0]   COUNT_RST    = 16'd16;

	// Register index codes of the configuration port.
	localparam logic [IDX_W-1:0] REG_BIAS_CH0  = 3'd0;
	localparam logic [IDX_W-1:0] REG_BIAS_CH1  = 3'd1;
	localparam logic [IDX_W-1:0] REG_BIAS_CH2  = 3'd2;
	localparam logic [IDX_W-1:0] REG_SHIFT     = 3'd3;
	localparam logic [IDX_W-1:0] REG_COUNT_CH0 = 3'd4;
	localparam logic [IDX_W-1:0] REG_COUNT_CH1 = 3'd5;
	localparam logic [IDX_W-1:0] REG_COUNT_CH2 = 3'd6;

	// One classified sample as it travels from the front end to the back end.
	typedef struct packed {
		logic [CH_W-1:0]         channel;
		logic signed [ADJ_W-1:0] adjusted;
	} item_t;

	typedef logic [CFG_CH-1:0][BIAS_W-1:0] bias_arr_t;
	typedef logic [CFG_CH-1:0][CNT_W-1:0]  count_arr_t;

endpackage

### hdl/mcba_front.sv
// Front end of the block averager: accepts samples, tags the scan channel,
// removes the bias and applies the arithmetic shift. Depends on mcba_pkg.
module mcba_front #(
	parameter int NUM_CHANNELS = mcba_pkg::NUM_CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mcba_pkg::SAMPLE_W-1:0]   sample,
	input  mcba_pkg::bias_arr_t             bias,
	input  logic [mcba_pkg::SHIFT_W-1:0]    shift,
	input  logic                            q_full,
	output logic                            q_push,
	output mcba_pkg::item_t                 q_item
);
	import mcba_pkg::*;

	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

	logic [CH_W-1:0]         ch_q;
	logic signed [ADJ_W-1:0] diff;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	assign diff            = $signed({1'b0, sample}) - $signed({1'b0, bias[ch_q]});
	assign q_item.channel  = ch_q;
	assign q_item.adjusted = diff >>> shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
		end else if (q_push) begin
			ch_q <= (ch_q == LAST_CH) ? '0 : ch_q + CH_W'(1);
		end
	end

endmodule

### hdl/mcba_queue.sv
// Short word queue between the front end and the back end of the averager.
// Depends on mcba_pkg for the item type and the depth.
module mcba_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mcba_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output mcba_pkg::item_t head
);
	import mcba_pkg::*;

	localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QDEPTH - 1);

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

### hdl/mcba_back.sv
// Back end of the averager: per-channel sums, counts and min/max, a serial
// divider for the block mean and the output register. Depends on mcba_pkg.
module mcba_back #(
	parameter int NUM_CHANNELS = mcba_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mcba_pkg::count_arr_t                count_cfg,
	input  logic                                q_empty,
	input  mcba_pkg::item_t                     head,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mcba_pkg::CH_W-1:0]           channel,
	output logic signed [mcba_pkg::ADJ_W-1:0]   adjusted,
	output logic                                block_done,
	output logic signed [mcba_pkg::ADJ_W-1:0]   mean,
	output logic [mcba_pkg::SPREAD_W-1:0]       spread
);
	import mcba_pkg::*;

	localparam int                CI_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int                STEP_W    = $clog2(ACC_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ACC_W - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

	state_t                  state_q;
	logic signed [ACC_W-1:0] acc_q    [NUM_CHANNELS];
	logic [CNT_W-1:0]        cnt_q    [NUM_CHANNELS];
	logic signed [ADJ_W-1:0] min_q    [NUM_CHANNELS];
	logic signed [ADJ_W-1:0] max_q    [NUM_CHANNELS];
	logic signed [ADJ_W-1:0] mean_q   [NUM_CHANNELS];
	logic [SPREAD_W-1:0]     spread_q [NUM_CHANNELS];

	logic [ACC_W-1:0]        div_num_q;
	logic [ACC_W-1:0]        div_quo_q;
	logic [CNT_W-1:0]        div_rem_q;
	logic [CNT_W-1:0]        div_den_q;
	logic                    div_neg_q;
	logic [STEP_W-1:0]       div_step_q;
	logic [CI_W-1:0]         div_ch_q;

	logic                    out_valid_q;
	logic [CH_W-1:0]         out_channel_q;
	logic signed [ADJ_W-1:0] out_adjusted_q;
	logic                    out_done_q;
	logic signed [ADJ_W-1:0] out_mean_q;
	logic [SPREAD_W-1:0]     out_spread_q;

	logic [CI_W-1:0]         ci;
	logic signed [ACC_W-1:0] adj_ext;
	logic signed [ACC_W-1:0] acc_sum;
	logic [ACC_W-1:0]        acc_mag;
	logic [CNT_W-1:0]        cnt_next;
	logic signed [ADJ_W-1:0] min_new;
	logic signed [ADJ_W-1:0] max_new;
	logic signed [ADJ_W:0]   spread_diff;
	logic [SPREAD_W-1:0]     spread_new;
	logic                    block_end;
	logic                    out_free;
	logic                    take;
	logic [CNT_W:0]          rem_shift;
	logic                    fits;
	logic [CNT_W:0]          rem_next;
	logic [ADJ_W-2:0]        mean_mag;
	logic signed [ADJ_W-1:0] mean_val;

	assign ci       = head.channel[CI_W-1:0];
	assign adj_ext  = ACC_W'(head.adjusted);
	assign acc_sum  = acc_q[ci] + adj_ext;
	assign acc_mag  = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);
	assign cnt_next = cnt_q[ci] + CNT_W'(1);
	assign min_new  = (head.adjusted < min_q[ci]) ? head.adjusted : min_q[ci];
	assign max_new  = (head.adjusted > max_q[ci]) ? head.adjusted : max_q[ci];

	// A block holds at least one sample, so max is never below min; the clamp is cheap.
	assign spread_diff = {max_new[ADJ_W-1], max_new} - {min_new[ADJ_W-1], min_new};
	assign spread_new  = spread_diff[ADJ_W] ? '0 : spread_diff[SPREAD_W-1:0];
	assign block_end   = (cnt_next >= count_cfg[head.channel]);

	assign out_free = !out_valid_q || out_ready;
	assign take     = (state_q == ST_IDLE) && !q_empty && out_free;
	assign q_pop    = take;

	// One restoring step of the magnitude division per cycle.
	assign rem_shift = {div_rem_q, div_num_q[ACC_W-1]};
	assign fits      = (rem_shift >= {1'b0, div_den_q});
	assign rem_next  = fits ? rem_shift - {1'b0, div_den_q} : rem_shift;

	assign mean_mag = (div_quo_q > ACC_W'(MEAN_MAX)) ? MEAN_MAX : div_quo_q[ADJ_W-2:0];
	assign mean_val = div_neg_q ? -$signed({1'b0, mean_mag}) : $signed({1'b0, mean_mag});

	assign out_valid  = out_valid_q;
	assign channel    = out_channel_q;
	assign adjusted   = out_adjusted_q;
	assign block_done = out_done_q;
	assign mean       = out_mean_q;
	assign spread     = out_spread_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				acc_q[i]    <= '0;
				cnt_q[i]    <= '0;
				min_q[i]    <= MIN_RESTART;
				max_q[i]    <= MAX_RESTART;
				mean_q[i]   <= '0;
				spread_q[i] <= '0;
			end
			div_num_q      <= '0;
			div_quo_q      <= '0;
			div_rem_q      <= '0;
			div_den_q      <= '0;
			div_neg_q      <= 1'b0;
			div_step_q     <= '0;
			div_ch_q       <= '0;
			out_valid_q    <= 1'b0;
			out_channel_q  <= '0;
			out_adjusted_q <= '0;
			out_done_q     <= 1'b0;
			out_mean_q     <= '0;
			out_spread_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						out_channel_q  <= head.channel;
						out_adjusted_q <= head.adjusted;
						if (block_end) begin
							acc_q[ci]    <= '0;
							cnt_q[ci]    <= '0;
							min_q[ci]    <= MIN_RESTART;
							max_q[ci]    <= MAX_RESTART;
							spread_q[ci] <= spread_new;
							out_done_q   <= 1'b1;
							out_spread_q <= spread_new;
							out_valid_q  <= 1'b0;
							div_num_q    <= acc_mag;
							div_neg_q    <= acc_sum[ACC_W-1];
							div_den_q    <= count_cfg[head.channel];
							div_rem_q    <= '0;
							div_quo_q    <= '0;
							div_step_q   <= '0;
							div_ch_q     <= ci;
							state_q      <= ST_DIV;
						end else begin
							acc_q[ci]    <= acc_sum;
							cnt_q[ci]    <= cnt_next;
							min_q[ci]    <= min_new;
							max_q[ci]    <= max_new;
							out_done_q   <= 1'b0;
							out_mean_q   <= mean_q[ci];
							out_spread_q <= spread_q[ci];
							out_valid_q  <= 1'b1;
						end
					end else if (out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				// The output register stays empty while the divider runs.
				ST_DIV: begin
					div_rem_q <= rem_next[CNT_W-1:0];
					div_quo_q <= {div_quo_q[ACC_W-2:0], fits};
					div_num_q <= {div_num_q[ACC_W-2:0], 1'b0};
					if (div_step_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end else begin
						div_step_q <= div_step_q + STEP_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						mean_q[div_ch_q] <= mean_val;
						out_mean_q       <= mean_val;
						out_valid_q      <= 1'b1;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/multichannel_adc_block_averager.sv
// Top level of the multichannel converter block averager.
// Holds the configuration registers and joins mcba_front, mcba_queue and mcba_back.
// Depends on mcba_pkg.

// Raw 10-bit samples arrive on the in_valid/in_ready channel and belong in turn to scan
// channels 0, 1, ... NUM_CHANNELS-1, wrapping after the last one. Every accepted word
// gives exactly one result word: the channel, the sample less its bias shifted right
// arithmetically, a flag for a completed averaging block, and the channel's latest block
// mean (truncated toward zero, held to -1023..1023) and spread (max minus min).
// The front end takes one sample per cycle while its two-word queue has room. The back
// end moves an ordinary sample to its output register whenever that register is free;
// a sample that closes a block holds it while the serial restoring divider works out
// the mean one quotient bit per cycle over the 27-bit sum. While a result waits in the
// output register, the front end keeps accepting until the queue is full. Configuration
// writes land at once with no handshake and must only be made while the block is idle;
// writing a zero block size stores one, and writes to unused indexes are ignored.
module multichannel_adc_block_averager #(
	parameter int NUM_CHANNELS = mcba_pkg::NUM_CHANNELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mcba_pkg::SAMPLE_W-1:0]       sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mcba_pkg::CH_W-1:0]           channel,
	output logic signed [mcba_pkg::ADJ_W-1:0]   adjusted,
	output logic                                block_done,
	output logic signed [mcba_pkg::ADJ_W-1:0]   mean,
	output logic [mcba_pkg::SPREAD_W-1:0]       spread,
	input  logic                                wr_en,
	input  logic [mcba_pkg::IDX_W-1:0]          wr_index,
	input  logic [mcba_pkg::DATA_W-1:0]         wr_data
);
	import mcba_pkg::*;

	// Configuration registers: bias per channel, the common shift and block sizes.
	bias_arr_t          bias_q;
	logic [SHIFT_W-1:0] shift_q;
	count_arr_t         count_q;
	logic [CNT_W-1:0]   count_wr;

	// Signals of the queue between the front end and the back end.
	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;
	item_t q_item;
	item_t q_head;

	// A block size of zero would give the divider a zero divisor, so it is stored as one.
	assign count_wr = (wr_data[CNT_W-1:0] == '0) ? CNT_W'(1) : wr_data[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q[0]  <= BIAS_RST_CH0;
			bias_q[1]  <= BIAS_RST_CH1;
			bias_q[2]  <= BIAS_RST_CH2;
			shift_q    <= SHIFT_RST;
			count_q[0] <= COUNT_RST;
			count_q[1] <= COUNT_RST;
			count_q[2] <= COUNT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_BIAS_CH0:  bias_q[0]  <= wr_data[BIAS_W-1:0];
				REG_BIAS_CH1:  bias_q[1]  <= wr_data[BIAS_W-1:0];
				REG_BIAS_CH2:  bias_q[2]  <= wr_data[BIAS_W-1:0];
				REG_SHIFT:     shift_q    <= wr_data[SHIFT_W-1:0];
				REG_COUNT_CH0: count_q[0] <= count_wr;
				REG_COUNT_CH1: count_q[1] <= count_wr;
				REG_COUNT_CH2: count_q[2] <= count_wr;
				default: begin
				end
			endcase
		end
	end

	// The front end tags each sample with its channel and adjusts it.
	mcba_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample   (sample),
		.bias     (bias_q),
		.shift    (shift_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (q_item)
	);

	// The queue lets the front end run on while the divider is busy.
	mcba_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	// The back end keeps the block statistics and drives the result word.
	mcba_back #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.count_cfg  (count_q),
		.q_empty    (q_empty),
		.head       (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.channel    (channel),
		.adjusted   (adjusted),
		.block_done (block_done),
		.mean       (mean),
		.spread     (spread)
	);

endmodule

### bench/multichannel_adc_block_averager_test.sv
// Self-checking testbench for the multichannel converter block averager.
// Drives directed and random samples with configuration phases and checks every result word.
// Depends on mcba_pkg and multichannel_adc_block_averager.
module multichannel_adc_block_averager_test;

	import mcba_pkg::*;

	// Index that no register answers to; writes to it must leave every setting alone.
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int SPREAD_TOP  = (1 << SPREAD_W) - 1;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASES      = 6;
	localparam int PHASE_WORDS = 200;

	// One result word as the block presents it.
	typedef struct packed {
		logic [CH_W-1:0]         channel;
		logic signed [ADJ_W-1:0] adjusted;
		logic                    block_done;
		logic signed [ADJ_W-1:0] mean;
		logic [SPREAD_W-1:0]     spread;
	} avg_word_t;

	// One row of the directed table: either a register write or a sample, the latter with
	// an optional hand-worked result.
	typedef struct {
		bit                  is_write;
		logic [IDX_W-1:0]    index;
		logic [DATA_W-1:0]   data;
		logic [SAMPLE_W-1:0] raw;
		bit                  known;
		avg_word_t           want;
	} step_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic [SAMPLE_W-1:0]        sample    = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [CH_W-1:0]            channel;
	logic signed [ADJ_W-1:0]    adjusted;
	logic                       block_done;
	logic signed [ADJ_W-1:0]    mean;
	logic [SPREAD_W-1:0]        spread;
	logic                       wr_en     = 1'b0;
	logic [IDX_W-1:0]           wr_index  = '0;
	logic [DATA_W-1:0]          wr_data   = '0;

	// Settings and per-channel state of the predictor, kept apart from the block.
	logic [BIAS_W-1:0]  bias_reg [CFG_CH];
	logic [SHIFT_W-1:0] shift_reg;
	logic [CNT_W-1:0]   block_len [CFG_CH];
	int                 lane;
	int                 acc_sum [CFG_CH];
	int                 taken [CFG_CH];
	int                 low_mark [CFG_CH];
	int                 high_mark [CFG_CH];
	int                 latched_mean [CFG_CH];
	int                 latched_spread [CFG_CH];

	avg_word_t awaited_words[$];
	step_t     steps[$];
	int        mismatches   = 0;
	int        send_idle    = 0;
	int        recv_idle    = 0;
	int        hold_asks    = 0;
	int        holds_served = 0;
	int        hold_left    = 0;

	multichannel_adc_block_averager u_top (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// A generous ceiling: a correct run needs a small fraction of this.
	initial begin
		#1_000_000;
		$display("Verification failed");
		$finish;
	end

	// Works out the result word for one accepted sample and moves the predictor on.
	// The difference is shifted arithmetically, so negative values round toward minus
	// infinity; the mean is an integer division, which truncates toward zero.
	function automatic avg_word_t average_sample(input logic [SAMPLE_W-1:0] raw);
		avg_word_t w;
		int        c;
		int        adj;
		int        quot;
		int        gap;
		c = lane;
		adj = (int'(raw) - int'(bias_reg[c])) >>> shift_reg;
		acc_sum[c] += adj;
		taken[c]++;
		if (low_mark[c] > adj)
			low_mark[c] = adj;
		if (high_mark[c] < adj)
			high_mark[c] = adj;
		w.block_done = 1'b0;
		// A block size lowered mid-block closes the block on the next sample, so the
		// comparison is at-or-above rather than equal, and the mean can then overflow.
		if (taken[c] >= int'(block_len[c])) begin
			w.block_done = 1'b1;
			taken[c] = 0;
			quot = acc_sum[c] / int'(block_len[c]);
			if (quot > int'(MEAN_MAX))
				quot = int'(MEAN_MAX);
			if (quot < -int'(MEAN_MAX))
				quot = -int'(MEAN_MAX);
			latched_mean[c] = quot;
			acc_sum[c] = 0;
			gap = high_mark[c] - low_mark[c];
			if (gap < 0)
				gap = 0;
			if (gap > SPREAD_TOP)
				gap = SPREAD_TOP;
			latched_spread[c] = gap;
			// The restart values are not true limits: a sample beyond them leaves the
			// opposite mark at its restart value, which shows up in the spread.
			low_mark[c] = int'(MIN_RESTART);
			high_mark[c] = int'(MAX_RESTART);
		end
		w.channel = CH_W'(c);
		w.adjusted = ADJ_W'(adj);
		w.mean = ADJ_W'(latched_mean[c]);
		w.spread = SPREAD_W'(latched_spread[c]);
		lane = (c + 1 >= NUM_CHANNELS_DEF) ? 0 : c + 1;
		return w;
	endfunction

	function automatic step_t write_row(input logic [IDX_W-1:0] idx,
					    input logic [DATA_W-1:0] val);
		step_t r;
		r.is_write = 1'b1;
		r.index = idx;
		r.data = val;
		r.raw = '0;
		r.known = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic step_t sample_row(input logic [SAMPLE_W-1:0] raw);
		step_t r;
		r = write_row(REG_UNUSED, '0);
		r.is_write = 1'b0;
		r.raw = raw;
		return r;
	endfunction

	function automatic step_t known_row(input logic [SAMPLE_W-1:0] raw, input int ch,
					    input int adj, input bit done, input int avg,
					    input int spr);
		step_t r;
		r = sample_row(raw);
		r.known = 1'b1;
		r.want.channel = CH_W'(ch);
		r.want.adjusted = ADJ_W'(adj);
		r.want.block_done = done;
		r.want.mean = ADJ_W'(avg);
		r.want.spread = SPREAD_W'(spr);
		return r;
	endfunction

	// Random register value: often an extreme, sometimes junk in the unused upper bits,
	// otherwise drawn from the range where the block does interesting work.
	function automatic logic [DATA_W-1:0] pick_value(input int top, input int lo, input int hi);
		case ($urandom_range(5))
			0: return '0;
			1: return DATA_W'(top);
			2: return DATA_W'($urandom);
			default: return DATA_W'($urandom_range(hi, lo));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("Mismatch on %s: got %0d, expected %0d", what, got, want);
	endtask

	// Stops offering words and waits until every expected result word has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
	endtask

	// Register writes are made only once the block is idle. Each write drops the enable
	// again before the task returns, so the enable never gets two assignments in one step.
	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		drain_results();
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			REG_BIAS_CH0:  bias_reg[0] = val[BIAS_W-1:0];
			REG_BIAS_CH1:  bias_reg[1] = val[BIAS_W-1:0];
			REG_BIAS_CH2:  bias_reg[2] = val[BIAS_W-1:0];
			REG_SHIFT:     shift_reg = val[SHIFT_W-1:0];
			REG_COUNT_CH0: block_len[0] = (val == '0) ? CNT_W'(1) : val;
			REG_COUNT_CH1: block_len[1] = (val == '0) ? CNT_W'(1) : val;
			REG_COUNT_CH2: block_len[2] = (val == '0) ? CNT_W'(1) : val;
			default: ;
		endcase
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one sample word, after a random gap, and holds it until accepted. The
	// expectation is the hand-worked one where the row carries it, the predictor's otherwise,
	// but the predictor is always stepped so that its state follows the block.
	task automatic offer_sample(input logic [SAMPLE_W-1:0] raw, input bit known,
				    input avg_word_t want);
		avg_word_t guess;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= raw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		guess = average_sample(raw);
		awaited_words.push_back(known ? want : guess);
	endtask

	// Receiver: random back-pressure, interrupted on request by one long hold-off, long
	// enough for the internal queue and the output register to fill and stall the input.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asks != holds_served) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			holds_served <= holds_served + 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Checker: every result word taken is compared field by field with the oldest
	// expectation. Values are sampled at the edge, before the block's registers move.
	always @(posedge clk) begin
		avg_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_words.size() == 0) begin
				report_mismatch("result word with none expected, channel", channel, 0);
			end else begin
				want = awaited_words.pop_front();
				if (channel !== want.channel)
					report_mismatch("channel", channel, want.channel);
				if (adjusted !== want.adjusted)
					report_mismatch("adjusted", adjusted, want.adjusted);
				if (block_done !== want.block_done)
					report_mismatch("block_done", block_done, want.block_done);
				if (mean !== want.mean)
					report_mismatch("mean", mean, want.mean);
				if (spread !== want.spread)
					report_mismatch("spread", spread, want.spread);
			end
		end
	end

	initial begin
		logic [SAMPLE_W-1:0] raw;

		// Predictor state after reset.
		lane = 0;
		shift_reg = SHIFT_RST;
		bias_reg[0] = BIAS_RST_CH0;
		bias_reg[1] = BIAS_RST_CH1;
		bias_reg[2] = BIAS_RST_CH2;
		for (int c = 0; c < CFG_CH; c++) begin
			block_len[c] = COUNT_RST;
			acc_sum[c] = 0;
			taken[c] = 0;
			low_mark[c] = int'(MIN_RESTART);
			high_mark[c] = int'(MAX_RESTART);
			latched_mean[c] = 0;
			latched_spread[c] = 0;
		end

		// Directed table. First the reset settings with extreme samples, nothing latched yet.
		steps.push_back(known_row(10'd0,    0, -511, 1'b0, 0, 0));
		steps.push_back(known_row(10'd1023, 1,  512, 1'b0, 0, 0));
		steps.push_back(known_row(10'd1023, 2, 1023, 1'b0, 0, 0));
		// A zero block size stores one; the bias write carries junk above bit nine; the
		// unused index must change nothing.
		steps.push_back(write_row(REG_COUNT_CH0, 16'd0));
		steps.push_back(write_row(REG_COUNT_CH1, 16'd1));
		steps.push_back(write_row(REG_COUNT_CH2, 16'd2));
		steps.push_back(write_row(REG_BIAS_CH0, 16'hFFFF));
		steps.push_back(write_row(REG_BIAS_CH1, 16'd0));
		steps.push_back(write_row(REG_BIAS_CH2, 16'd0));
		steps.push_back(write_row(REG_UNUSED, 16'hFFFF));
		// Block sizes lowered mid-block: each channel closes now. Channels nought and one
		// saturate the mean; channel two shows the restart value of the minimum in its spread.
		steps.push_back(known_row(10'd0,    0, -1023, 1'b1, -1023, 512));
		steps.push_back(known_row(10'd1023, 1,  1023, 1'b1,  1023, 511));
		steps.push_back(known_row(10'd1023, 2,  1023, 1'b1,  1023,  23));
		// Widest shift: positive differences shift to nought, negative ones to minus one.
		steps.push_back(write_row(REG_SHIFT, 16'hFFFF));
		steps.push_back(write_row(REG_BIAS_CH0, 16'd0));
		steps.push_back(write_row(REG_BIAS_CH2, 16'd1));
		steps.push_back(known_row(10'd1023, 0,  0, 1'b1,    0,  0));
		steps.push_back(known_row(10'd0,    1,  0, 1'b1,    0,  0));
		steps.push_back(known_row(10'd0,    2, -1, 1'b0, 1023, 23));
		// A moderate shift and the largest block size, then samples left to the predictor.
		steps.push_back(write_row(REG_SHIFT, 16'd4));
		steps.push_back(write_row(REG_COUNT_CH0, 16'hFFFF));
		steps.push_back(write_row(REG_COUNT_CH1, 16'd3));
		steps.push_back(write_row(REG_COUNT_CH2, 16'd16));
		steps.push_back(sample_row(10'h155));
		steps.push_back(sample_row(10'h2AA));
		steps.push_back(sample_row(10'h3FF));
		steps.push_back(sample_row(10'h000));
		steps.push_back(sample_row(10'h200));
		steps.push_back(sample_row(10'h1FF));
		steps.push_back(sample_row(10'h001));
		steps.push_back(sample_row(10'h3FE));
		steps.push_back(sample_row(10'h0F0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (steps[i]) begin
			if (steps[i].is_write)
				write_register(steps[i].index, steps[i].data);
			else
				offer_sample(steps[i].raw, steps[i].known, steps[i].want);
		end

		// Random phases. Each begins idle with fresh settings; the first pair has the sender
		// idling lightly and the receiver heavily, the second pair the reverse, the last
		// pair no idling at all. Every other phase also asks for one long receiver hold-off.
		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle = (ph < 2) ? 19 : (ph < 4) ? 47 : 0;
			recv_idle <= (ph < 2) ? 47 : (ph < 4) ? 19 : 0;
			write_register(REG_BIAS_CH0, pick_value(1023, 0, 1023));
			write_register(REG_BIAS_CH1, pick_value(1023, 0, 1023));
			write_register(REG_BIAS_CH2, pick_value(1023, 0, 1023));
			write_register(REG_SHIFT, pick_value(15, 1, 4));
			write_register(REG_COUNT_CH0, pick_value(65535, 1, 6));
			write_register(REG_COUNT_CH1, pick_value(65535, 1, 6));
			write_register(REG_COUNT_CH2, pick_value(65535, 1, 6));
			write_register(REG_UNUSED, DATA_W'($urandom));
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n == 60 && ph % 2 == 0)
					hold_asks <= hold_asks + 1;
				if ($urandom_range(7) == 0)
					raw = $urandom_range(1) ? {SAMPLE_W{1'b1}} : {SAMPLE_W{1'b0}};
				else
					raw = SAMPLE_W'($urandom_range(1023));
				offer_sample(raw, 1'b0, '0);
			end
		end

		// Let any stray word show itself after the last expected one has gone.
		drain_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
hdl/mcba_pkg.sv
hdl/mcba_front.sv
hdl/mcba_queue.sv
hdl/mcba_back.sv
hdl/multichannel_adc_block_averager.sv
bench/multichannel_adc_block_averager_test.sv
